// ----- src/scm_pkg.sv -----
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types, constants and codes of the strided convolution MAC core.
// ----------------------------------------------------------------------------
package scm_pkg;

    // Data path and store geometry
    localparam int DATA_W       = 16;
    localparam int ACC_W        = 48;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int IMAGE_WORDS  = 262144;
    localparam int WEIGHT_WORDS = 65536;
    localparam int IMG_AW       = 18;
    localparam int WGT_AW       = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_IMG_ROWS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_COLS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE       = 3'd6;

    // Commands
    localparam logic [1:0] CMD_LOAD_PIXEL  = 2'd0;
    localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd1;
    localparam logic [1:0] CMD_COMPUTE     = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [17:0]       address;
        logic signed [15:0] value;
        logic [8:0]        out_channel;
        logic [8:0]        out_row;
        logic [8:0]        out_col;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] sum;
        logic               error;
    } out_item_t;

    typedef struct packed {
        logic [9:0] img_rows;
        logic [9:0] img_cols;
        logic [9:0] in_channels;
        logic [3:0] kernel_rows;
        logic [3:0] kernel_cols;
        logic [9:0] out_channels;
        logic [3:0] stride;
    } cfg_t;

    // Window geometry handed from the check unit to the sequencer
    typedef struct packed {
        logic              bad;
        logic              empty;
        logic [IMG_AW-1:0] off0;
        logic [IMG_AW-1:0] plane;
        logic [WGT_AW-1:0] w_base;
    } geom_t;

endpackage

// ----- src/scm_geom.sv -----
// ----------------------------------------------------------------------------
// scm_geom
// Three-stage window geometry unit: computes the window origin, channel plane
// size and filter base, and checks grid and store bounds for one compute.
// ----------------------------------------------------------------------------
module scm_geom (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  scm_pkg::cfg_t     cfg,
    input  logic [8:0]        oc,
    input  logic [8:0]        orow,
    input  logic [8:0]        ocol,
    output logic              done,
    output scm_pkg::geom_t    geom
);

    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic        done_reg;

    logic [12:0] r0_reg;
    logic [12:0] c0_reg;
    logic [19:0] plane_reg;
    logic [7:0]  kk_reg;
    logic [18:0] tw_reg;
    logic        bad0_reg;

    logic [23:0] off0_reg;
    logic [29:0] lastc_reg;
    logic [17:0] ikk_reg;
    logic [26:0] wbase_reg;
    logic [13:0] tail_reg;
    logic        bad1_reg;
    logic        empty_reg;

    logic [31:0] last_pix;
    logic [31:0] last_w;

    scm_pkg::geom_t geom_reg;

    // Advance the stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    // Stage 1: origin, plane size, kernel area, filter group index
    always_ff @(posedge aclk) begin
        if (start) begin
            r0_reg    <= 13'(orow) * 13'(cfg.stride);
            c0_reg    <= 13'(ocol) * 13'(cfg.stride);
            plane_reg <= 20'(cfg.img_rows) * 20'(cfg.img_cols);
            kk_reg    <= 8'(cfg.kernel_rows) * 8'(cfg.kernel_cols);
            tw_reg    <= 19'(oc) * 19'(cfg.in_channels);
            bad0_reg  <= (cfg.stride == 4'd0)
                      || (10'(cfg.kernel_rows) > cfg.img_rows)
                      || (10'(cfg.kernel_cols) > cfg.img_cols)
                      || (10'(oc) >= cfg.out_channels);
        end
    end

    // Stage 2: window offset, last channel base, filter base, grid check
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            off0_reg  <= 24'(r0_reg) * 24'(cfg.img_cols) + 24'(c0_reg);
            lastc_reg <= 30'(cfg.in_channels - 10'd1) * 30'(plane_reg);
            ikk_reg   <= 18'(cfg.in_channels) * 18'(kk_reg);
            wbase_reg <= 27'(tw_reg) * 27'(kk_reg);
            tail_reg  <= 14'(cfg.kernel_rows - 4'd1) * 14'(cfg.img_cols)
                       + 14'(cfg.kernel_cols - 4'd1);
            bad1_reg  <= bad0_reg
                      || (r0_reg > 13'(cfg.img_rows - 10'(cfg.kernel_rows)))
                      || (c0_reg > 13'(cfg.img_cols - 10'(cfg.kernel_cols)));
            empty_reg <= (cfg.in_channels == 10'd0) || (kk_reg == 8'd0);
        end
    end

    // Stage 3: last addresses touched against the store sizes
    assign last_pix = 32'(lastc_reg) + 32'(off0_reg) + 32'(tail_reg);
    assign last_w   = 32'(wbase_reg) + 32'(ikk_reg) - 32'd1;

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            geom_reg.bad    <= bad1_reg || (!empty_reg
                             && ((last_pix >= 32'(scm_pkg::IMAGE_WORDS))
                             ||  (last_w   >= 32'(scm_pkg::WEIGHT_WORDS))));
            geom_reg.empty  <= empty_reg;
            geom_reg.off0   <= off0_reg[scm_pkg::IMG_AW-1:0];
            geom_reg.plane  <= plane_reg[scm_pkg::IMG_AW-1:0];
            geom_reg.w_base <= wbase_reg[scm_pkg::WGT_AW-1:0];
        end
    end

    assign done = done_reg;
    assign geom = geom_reg;

endmodule

// ----- src/strided_conv2d_mac_core.sv -----
// ----------------------------------------------------------------------------
// strided_conv2d_mac_core
// Multi-channel valid 2D convolution with stride over on-chip image and
// weight stores, one multiply-accumulate per cycle during a window walk.
// ----------------------------------------------------------------------------
// Every transfer on s_ gives exactly one result on m_. A load of a pixel or a
// weight writes the store at the transfer and then hands its result to the
// output register. A compute runs the transfer, the geometry and bounds unit,
// the window walk with one product per tap (each store has a single read port
// with registered data, so the window is walked one tap a cycle), the drain of
// the read and multiply stages and the posting of the result. A failed bounds
// check skips the walk. Stores come up undefined and need no clearing pass; a
// compute over entries never loaded returns an undefined sum. Configuration
// must be written only while the block is idle; the block itself does not
// enforce this.
module strided_conv2d_mac_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [scm_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [scm_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  scm_pkg::in_item_t                     s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output scm_pkg::out_item_t                    m_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GEOM  = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0]                          state_reg;
    scm_pkg::cfg_t                       cfg_reg;

    logic                                s_fire;
    logic                                pix_we;
    logic                                wgt_we;
    logic                                geom_start;
    logic                                geom_done;
    scm_pkg::geom_t                      geom;

    logic [scm_pkg::DATA_W-1:0]          img_mem [scm_pkg::IMAGE_WORDS];
    logic [scm_pkg::DATA_W-1:0]          wgt_mem [scm_pkg::WEIGHT_WORDS];
    logic signed [scm_pkg::DATA_W-1:0]   img_rdata_reg;
    logic signed [scm_pkg::DATA_W-1:0]   wgt_rdata_reg;

    logic [scm_pkg::IMG_AW-1:0]          pa_reg;
    logic [scm_pkg::IMG_AW-1:0]          row_ptr_reg;
    logic [scm_pkg::IMG_AW-1:0]          chan_ptr_reg;
    logic [scm_pkg::IMG_AW-1:0]          plane_reg;
    logic [scm_pkg::WGT_AW-1:0]          wa_reg;
    logic [9:0]                          ch_reg;
    logic [3:0]                          row_reg;
    logic [3:0]                          col_reg;
    logic                                last_col;
    logic                                last_row;
    logic                                last_ch;

    logic                                rd_valid_reg;
    logic                                prod_valid_reg;
    logic signed [scm_pkg::PROD_W-1:0]   prod_reg;
    logic [scm_pkg::ACC_W-1:0]           acc_reg;

    scm_pkg::out_item_t                  res_reg;
    scm_pkg::out_item_t                  m_data_reg;
    logic                                m_valid_reg;
    logic                                out_free;

    assign s_ready    = (state_reg == S_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign pix_we     = s_fire && (s_data.command == scm_pkg::CMD_LOAD_PIXEL)
                     && (32'(s_data.address) < 32'(scm_pkg::IMAGE_WORDS));
    assign wgt_we     = s_fire && (s_data.command == scm_pkg::CMD_LOAD_WEIGHT)
                     && (32'(s_data.address) < 32'(scm_pkg::WEIGHT_WORDS));
    assign geom_start = s_fire && (s_data.command == scm_pkg::CMD_COMPUTE);
    assign out_free   = !m_valid_reg || m_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.img_rows     <= 10'd227;
            cfg_reg.img_cols     <= 10'd227;
            cfg_reg.in_channels  <= 10'd3;
            cfg_reg.kernel_rows  <= 4'd11;
            cfg_reg.kernel_cols  <= 4'd11;
            cfg_reg.out_channels <= 10'd96;
            cfg_reg.stride       <= 4'd4;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                scm_pkg::REG_IMG_ROWS:     cfg_reg.img_rows     <= cfg_wdata;
                scm_pkg::REG_IMG_COLS:     cfg_reg.img_cols     <= cfg_wdata;
                scm_pkg::REG_IN_CHANNELS:  cfg_reg.in_channels  <= cfg_wdata;
                scm_pkg::REG_KERNEL_ROWS:  cfg_reg.kernel_rows  <= cfg_wdata[3:0];
                scm_pkg::REG_KERNEL_COLS:  cfg_reg.kernel_cols  <= cfg_wdata[3:0];
                scm_pkg::REG_OUT_CHANNELS: cfg_reg.out_channels <= cfg_wdata;
                scm_pkg::REG_STRIDE:       cfg_reg.stride       <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Geometry and bounds check
    scm_geom u_geom (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (geom_start),
        .cfg     (cfg_reg),
        .oc      (s_data.out_channel),
        .orow    (s_data.out_row),
        .ocol    (s_data.out_col),
        .done    (geom_done),
        .geom    (geom)
    );

    // Image store: write on load, read the current window tap every cycle
    always_ff @(posedge aclk) begin
        if (pix_we) begin
            img_mem[s_data.address[scm_pkg::IMG_AW-1:0]] <= s_data.value;
        end
        img_rdata_reg <= img_mem[pa_reg];
    end

    // Weight store: same scheme
    always_ff @(posedge aclk) begin
        if (wgt_we) begin
            wgt_mem[s_data.address[scm_pkg::WGT_AW-1:0]] <= s_data.value;
        end
        wgt_rdata_reg <= wgt_mem[wa_reg];
    end

    assign last_col = (col_reg == cfg_reg.kernel_cols - 4'd1);
    assign last_row = (row_reg == cfg_reg.kernel_rows - 4'd1);
    assign last_ch  = (ch_reg  == cfg_reg.in_channels - 10'd1);

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        res_reg.sum <= '0;
                        case (s_data.command)
                            scm_pkg::CMD_LOAD_PIXEL: begin
                                res_reg.error <= !pix_we;
                                state_reg     <= S_RESP;
                            end
                            scm_pkg::CMD_LOAD_WEIGHT: begin
                                res_reg.error <= !wgt_we;
                                state_reg     <= S_RESP;
                            end
                            scm_pkg::CMD_COMPUTE: begin
                                state_reg <= S_GEOM;
                            end
                            default: begin
                                res_reg.error <= 1'b1;
                                state_reg     <= S_RESP;
                            end
                        endcase
                    end
                end
                S_GEOM: begin
                    if (geom_done) begin
                        res_reg.sum   <= '0;
                        res_reg.error <= geom.bad;
                        pa_reg        <= geom.off0;
                        row_ptr_reg   <= geom.off0;
                        chan_ptr_reg  <= geom.off0;
                        plane_reg     <= geom.plane;
                        wa_reg        <= geom.w_base;
                        ch_reg        <= '0;
                        row_reg       <= '0;
                        col_reg       <= '0;
                        if (geom.bad || geom.empty) begin
                            state_reg <= S_RESP;
                        end else begin
                            state_reg <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    // Advance one tap: column, then row, then channel
                    wa_reg <= wa_reg + 1'b1;
                    if (!last_col) begin
                        col_reg <= col_reg + 4'd1;
                        pa_reg  <= pa_reg + 1'b1;
                    end else if (!last_row) begin
                        col_reg     <= '0;
                        row_reg     <= row_reg + 4'd1;
                        row_ptr_reg <= row_ptr_reg + scm_pkg::IMG_AW'(cfg_reg.img_cols);
                        pa_reg      <= row_ptr_reg + scm_pkg::IMG_AW'(cfg_reg.img_cols);
                    end else if (!last_ch) begin
                        col_reg      <= '0;
                        row_reg      <= '0;
                        ch_reg       <= ch_reg + 10'd1;
                        chan_ptr_reg <= chan_ptr_reg + plane_reg;
                        row_ptr_reg  <= chan_ptr_reg + plane_reg;
                        pa_reg       <= chan_ptr_reg + plane_reg;
                    end else begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!rd_valid_reg && !prod_valid_reg) begin
                        res_reg.sum   <= acc_reg;
                        res_reg.error <= 1'b0;
                        state_reg     <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Read, multiply and accumulate stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg   <= (state_reg == S_RUN);
            prod_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= img_rdata_reg * wgt_rdata_reg;
        if (state_reg == S_GEOM) begin
            acc_reg <= '0;
        end else if (prod_valid_reg) begin
            acc_reg <= acc_reg
                     + {{(scm_pkg::ACC_W - scm_pkg::PROD_W){prod_reg[scm_pkg::PROD_W-1]}},
                        prod_reg};
        end
    end

    // Output register: load from the staged result, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_RESP) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_RESP) && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Read pipeline only carries taps of a window walk
    a_rd_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (state_reg == S_RUN || state_reg == S_DRAIN))
        else $error("store read in flight outside a window walk");

    // Geometry result arrives only while the sequencer waits for it
    a_geom_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        geom_done |-> (state_reg == S_GEOM))
        else $error("geometry result with no compute pending");

    // A posted result is presented in the next cycle
    a_resp_post: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && out_free) |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("result not posted");

    // Drain is entered with the last tap still in the read stage
    a_drain_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DRAIN && $past(state_reg) == S_RUN) |-> rd_valid_reg)
        else $error("drain entered with empty read stage");

    // No store write while a compute is running
    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (pix_we || wgt_we) |-> (state_reg == S_IDLE))
        else $error("store write outside idle");

endmodule

// ----- tb/sv/strided_conv2d_mac_core_tb.sv -----
// ----------------------------------------------------------------------------
// strided_conv2d_mac_core_tb
// Self-checking regression for the strided convolution MAC core. Loads pixels
// and weights, runs computes over a series of layer geometries (reset values,
// unit size, degenerate ones, then the widest size and random small layers),
// predicts every result in the bench and checks each m_ transfer in order.
// ----------------------------------------------------------------------------
module strided_conv2d_mac_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scm_pkg::*;

    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam int unsigned ITEM_TARGET    = 1650;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned REPORT_LIMIT   = 40;
    localparam int unsigned PRELOAD_LIMIT  = 600;

    typedef enum logic [1:0] {SINK_OPEN, SINK_CHOPPY, SINK_TRICKLE} sink_mode_e;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    // Bench copy of the stores and of the layer geometry
    logic signed [15:0] pix_mem [IMAGE_WORDS];
    bit                 pix_set [IMAGE_WORDS];
    logic signed [15:0] wgt_mem [WEIGHT_WORDS];
    bit                 wgt_set [WEIGHT_WORDS];
    cfg_t               layer_cfg;

    out_item_t   outcomes_due [$];
    int unsigned fail_count     = 0;
    int unsigned items_sent     = 0;
    int unsigned burst_left     = 0;
    bit          gaps_on        = 1'b1;
    bit          drained_midway = 1'b0;

    bit          s_fire = 1'b0;
    bit          m_fire = 1'b0;
    out_item_t   m_hold;
    int unsigned stall_cycles = 0;
    logic [8:0]  sink_count   = '0;
    sink_mode_e  sink_mode    = SINK_OPEN;

    strided_conv2d_mac_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Geometry helpers
    // ------------------------------------------------------------------
    function automatic cfg_t geometry(int unsigned rows, int unsigned cols, int unsigned chans,
                                      int unsigned krows, int unsigned kcols,
                                      int unsigned filters, int unsigned step);
        cfg_t g;
        g.img_rows     = 10'(rows);
        g.img_cols     = 10'(cols);
        g.in_channels  = 10'(chans);
        g.kernel_rows  = 4'(krows);
        g.kernel_cols  = 4'(kcols);
        g.out_channels = 10'(filters);
        g.stride       = 4'(step);
        return g;
    endfunction

    // Output positions along one axis, zero when no window fits or the stride is zero
    function automatic longint unsigned out_span(longint unsigned img, longint unsigned kern);
        longint unsigned st;
        st = layer_cfg.stride;
        if (st == 0 || kern > img) return 0;
        return (img - kern) / st + 1;
    endfunction

    function automatic longint unsigned pixel_span();
        longint unsigned n;
        n = layer_cfg.in_channels;
        n = n * layer_cfg.img_rows * layer_cfg.img_cols;
        return (n > IMAGE_WORDS) ? IMAGE_WORDS : n;
    endfunction

    function automatic longint unsigned weight_span();
        longint unsigned n;
        n = layer_cfg.out_channels;
        n = n * layer_cfg.in_channels * layer_cfg.kernel_rows * layer_cfg.kernel_cols;
        return (n > WEIGHT_WORDS) ? WEIGHT_WORDS : n;
    endfunction

    // True when a compute at these coordinates must fail
    function automatic bit off_limits(longint unsigned oc, longint unsigned row,
                                      longint unsigned col);
        longint unsigned nch, ir, ic, kr, kc, st, rs, cs, last_pix, last_w;
        nch = layer_cfg.in_channels;
        ir  = layer_cfg.img_rows;
        ic  = layer_cfg.img_cols;
        kr  = layer_cfg.kernel_rows;
        kc  = layer_cfg.kernel_cols;
        st  = layer_cfg.stride;
        rs  = out_span(ir, kr);
        cs  = out_span(ic, kc);
        if (rs == 0 || cs == 0) return 1'b1;
        if (oc >= layer_cfg.out_channels || row >= rs || col >= cs) return 1'b1;
        if (nch != 0 && kr != 0 && kc != 0) begin
            last_pix = ((nch - 1) * ir + row * st + kr - 1) * ic + col * st + kc - 1;
            last_w   = ((oc * nch + nch - 1) * kr + kr - 1) * kc + kc - 1;
            if (last_pix >= IMAGE_WORDS || last_w >= WEIGHT_WORDS) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Sum the window products; flag whether every tap was loaded
    function automatic logic [47:0] walk_window(input longint unsigned oc,
                                                input longint unsigned row,
                                                input longint unsigned col,
                                                output bit complete);
        longint unsigned nch, ir, ic, kr, kc, r0, c0, pa, wa;
        longint          prod;
        logic [47:0]     acc;
        nch = layer_cfg.in_channels;
        ir  = layer_cfg.img_rows;
        ic  = layer_cfg.img_cols;
        kr  = layer_cfg.kernel_rows;
        kc  = layer_cfg.kernel_cols;
        r0  = row * layer_cfg.stride;
        c0  = col * layer_cfg.stride;
        acc = '0;
        complete = 1'b1;
        for (longint unsigned ch = 0; ch < nch; ch++) begin
            for (longint unsigned i = 0; i < kr; i++) begin
                for (longint unsigned j = 0; j < kc; j++) begin
                    pa = (ch * ir + r0 + i) * ic + c0 + j;
                    wa = ((oc * nch + ch) * kr + i) * kc + j;
                    if (!pix_set[pa] || !wgt_set[wa]) complete = 1'b0;
                    prod = longint'(pix_mem[pa]) * longint'(wgt_mem[wa]);
                    // wrap in the 48-bit accumulator
                    acc = acc + prod[47:0];
                end
            end
        end
        return acc;
    endfunction

    // Apply one accepted command to the bench stores and return its result
    function automatic out_item_t mac_outcome(in_item_t it);
        out_item_t r;
        bit        complete;
        r = '0;
        case (it.command)
            CMD_LOAD_PIXEL: begin
                if (it.address < IMAGE_WORDS) begin
                    pix_mem[it.address] = it.value;
                    pix_set[it.address] = 1'b1;
                end else begin
                    r.error = 1'b1;
                end
            end
            CMD_LOAD_WEIGHT: begin
                if (it.address < WEIGHT_WORDS) begin
                    wgt_mem[it.address[15:0]] = it.value;
                    wgt_set[it.address[15:0]] = 1'b1;
                end else begin
                    r.error = 1'b1;
                end
            end
            CMD_COMPUTE: begin
                if (off_limits(it.out_channel, it.out_row, it.out_col)) begin
                    r.error = 1'b1;
                end else begin
                    r.sum = walk_window(it.out_channel, it.out_row, it.out_col, complete);
                end
            end
            default: begin
                r.error = 1'b1;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    function automatic in_item_t noise_item();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    function automatic in_item_t load_word(logic [1:0] cmd, logic [17:0] addr, logic [15:0] val);
        in_item_t it;
        it = noise_item();
        it.command = cmd;
        it.address = addr;
        it.value   = val;
        return it;
    endfunction

    function automatic in_item_t compute_at(int unsigned oc, int unsigned row, int unsigned col);
        in_item_t it;
        it = noise_item();
        it.command     = CMD_COMPUTE;
        it.out_channel = 9'(oc);
        it.out_row     = 9'(row);
        it.out_col     = 9'(col);
        return it;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random command; computes never touch an unloaded tap
    function automatic in_item_t next_random_item();
        in_item_t        it;
        int unsigned     pick;
        longint unsigned rs, cs, pspan, wspan;
        bit              complete;
        pick  = $urandom_range(0, 99);
        pspan = pixel_span();
        wspan = weight_span();
        if (pick < 65) begin
            rs = out_span(layer_cfg.img_rows, layer_cfg.kernel_rows);
            cs = out_span(layer_cfg.img_cols, layer_cfg.kernel_cols);
            for (int unsigned tries = 0; tries < 8; tries++) begin
                it = noise_item();
                it.command = CMD_COMPUTE;
                if (pick < 55) begin
                    if (layer_cfg.out_channels != 0)
                        it.out_channel = 9'($urandom_range(0, layer_cfg.out_channels - 1));
                    if (rs != 0) it.out_row = 9'($urandom_range(0, rs - 1));
                    if (cs != 0) it.out_col = 9'($urandom_range(0, cs - 1));
                end
                if (off_limits(it.out_channel, it.out_row, it.out_col)) return it;
                void'(walk_window(it.out_channel, it.out_row, it.out_col, complete));
                if (complete) return it;
            end
            // fall back to a pixel load when no loaded window turned up
            return load_word(CMD_LOAD_PIXEL, 18'($urandom_range(0, pspan - 1)), rand_sample());
        end
        if (pick < 85 && pspan != 0)
            return load_word(CMD_LOAD_PIXEL, 18'($urandom_range(0, pspan - 1)), rand_sample());
        if (pick < 90 && wspan != 0)
            return load_word(CMD_LOAD_WEIGHT, 18'($urandom_range(0, wspan - 1)), rand_sample());
        if (pick < 94)
            return load_word(CMD_LOAD_PIXEL, 18'($urandom), rand_sample());
        if (pick < 97)
            return load_word(CMD_LOAD_WEIGHT, 18'($urandom), rand_sample());
        it = noise_item();
        it.command = CMD_UNUSED;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Sender, register writes, drain
    // ------------------------------------------------------------------
    task automatic send_item(input in_item_t item);
        // insert a gap between bursts
        if (gaps_on && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left != 0) burst_left--;
        s_valid <= 1'b1;
        s_data  <= item;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        outcomes_due.push_back(mac_outcome(item));
        items_sent++;
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outcomes_due.size() != 0);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_IMG_ROWS:     layer_cfg.img_rows     = val;
            REG_IMG_COLS:     layer_cfg.img_cols     = val;
            REG_IN_CHANNELS:  layer_cfg.in_channels  = val;
            REG_KERNEL_ROWS:  layer_cfg.kernel_rows  = val[3:0];
            REG_KERNEL_COLS:  layer_cfg.kernel_cols  = val[3:0];
            REG_OUT_CHANNELS: layer_cfg.out_channels = val;
            REG_STRIDE:       layer_cfg.stride       = val[3:0];
            default: ;
        endcase
    endtask

    // Reprogram the layer once the core is idle
    task automatic apply_cfg(input cfg_t g);
        wait_drain();
        write_reg(REG_IMG_ROWS,     g.img_rows);
        write_reg(REG_IMG_COLS,     g.img_cols);
        write_reg(REG_IN_CHANNELS,  g.in_channels);
        write_reg(REG_KERNEL_ROWS,  g.kernel_rows);
        write_reg(REG_KERNEL_COLS,  g.kernel_cols);
        write_reg(REG_OUT_CHANNELS, g.out_channels);
        write_reg(REG_STRIDE,       g.stride);
    endtask

    // Fill the whole image and filter bank of a small layer
    task automatic load_layer();
        longint unsigned pspan, wspan;
        pspan = pixel_span();
        wspan = weight_span();
        if (pspan + wspan > PRELOAD_LIMIT) return;
        for (longint unsigned a = 0; a < pspan; a++)
            send_item(load_word(CMD_LOAD_PIXEL, 18'(a), rand_sample()));
        for (longint unsigned a = 0; a < wspan; a++)
            send_item(load_word(CMD_LOAD_WEIGHT, 18'(a), rand_sample()));
    endtask

    task automatic run_layer(input cfg_t g, input int unsigned n_ops);
        apply_cfg(g);
        gaps_on = ($urandom_range(0, 3) != 0);
        load_layer();
        for (int unsigned k = 0; k < n_ops; k++) begin
            // hold the sender until every pending result is back
            if (k == n_ops / 2 && (!drained_midway || $urandom_range(0, 2) == 0)) begin
                drained_midway = 1'b1;
                wait_drain();
            end
            send_item(next_random_item());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_geometry();
        in_item_t it;
        send_item(load_word(CMD_LOAD_PIXEL, 18'd0, 16'h7fff));
        send_item(load_word(CMD_LOAD_PIXEL, 18'h3ffff, 16'h8000));
        send_item(load_word(CMD_LOAD_WEIGHT, 18'd0, 16'hffff));
        send_item(load_word(CMD_LOAD_WEIGHT, 18'h0ffff, 16'h0001));
        // weight addresses past the store
        send_item(load_word(CMD_LOAD_WEIGHT, 18'h10000, 16'h1234));
        send_item(load_word(CMD_LOAD_WEIGHT, 18'h3ffff, 16'h0000));
        it = noise_item();
        it.command = CMD_UNUSED;
        send_item(it);
        // off the 96 x 55 x 55 output grid
        send_item(compute_at(96, 0, 0));
        send_item(compute_at(0, 55, 0));
        send_item(compute_at(0, 0, 55));
        send_item(compute_at(511, 511, 511));
    endtask

    task automatic test_unit_geometry();
        apply_cfg(geometry(1, 1, 1, 1, 1, 1, 1));
        send_item(load_word(CMD_LOAD_PIXEL, 18'd0, 16'h8000));
        send_item(load_word(CMD_LOAD_WEIGHT, 18'd0, 16'h8000));
        send_item(compute_at(0, 0, 0));
        send_item(compute_at(0, 1, 0));
        send_item(load_word(CMD_LOAD_PIXEL, 18'd0, 16'h7fff));
        send_item(compute_at(0, 0, 0));
    endtask

    task automatic test_degenerate_geometry();
        // zero stride
        apply_cfg(geometry(1, 1, 1, 1, 1, 1, 0));
        send_item(compute_at(0, 0, 0));
        // no input channels: empty sum
        apply_cfg(geometry(1, 1, 0, 1, 1, 1, 1));
        send_item(compute_at(0, 0, 0));
        // zero-size kernels
        apply_cfg(geometry(2, 2, 1, 0, 0, 1, 1));
        send_item(compute_at(0, 2, 2));
        apply_cfg(geometry(1, 1, 1, 0, 1, 1, 1));
        send_item(compute_at(0, 1, 0));
        // kernel taller than the image
        apply_cfg(geometry(1, 1, 1, 2, 1, 1, 1));
        send_item(compute_at(0, 0, 0));
        // filter runs past the weight store
        apply_cfg(geometry(16, 16, 2, 15, 15, 512, 1));
        send_item(compute_at(300, 0, 0));
        // window runs past the image store
        apply_cfg(geometry(512, 512, 2, 1, 1, 1, 1));
        send_item(compute_at(0, 0, 0));
    endtask

    task automatic test_random_layers();
        cfg_t g;
        // widest geometry: every compute misses the stores
        run_layer(geometry(512, 512, 512, 15, 15, 512, 8), 60);
        // largest kernel over a single window
        run_layer(geometry(15, 15, 1, 15, 15, 1, 8), 30);
        while (items_sent < ITEM_TARGET) begin
            g = geometry($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 2),
                         $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 3),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                     : $urandom_range(1, 2));
            run_layer(g, 120);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking, receiver stalls, watchdog
    // ------------------------------------------------------------------
    function automatic void check_outcome(input out_item_t got);
        out_item_t want;
        if (outcomes_due.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
                $display("%0t ns: result with none due: expected nothing, actual sum %0d error %0b",
                         $time, got.sum, got.error);
            fail_count++;
            return;
        end
        want = outcomes_due.pop_front();
        if (got.sum !== want.sum) begin
            if (fail_count < REPORT_LIMIT)
                $display("%0t ns: sum mismatch: expected %0d, actual %0d",
                         $time, want.sum, got.sum);
            fail_count++;
        end
        if (got.error !== want.error) begin
            if (fail_count < REPORT_LIMIT)
                $display("%0t ns: error mismatch: expected %0b, actual %0b",
                         $time, want.error, got.error);
            fail_count++;
        end
    endfunction

    // Sample both handshakes mid-cycle, ahead of the edge that completes them
    always @(negedge aclk) begin
        s_fire = aresetn && s_valid && s_ready;
        m_fire = aresetn && m_valid && m_ready;
        m_hold = m_data;
    end

    always @(posedge aclk) begin
        if (m_fire) check_outcome(m_hold);
        if (!aresetn || s_fire || m_fire) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Receiver: switch between open, choppy and trickle modes at random
    always @(posedge aclk) begin
        sink_count <= sink_count + 1'b1;
        if (sink_count[7:0] == 8'hff) sink_mode <= sink_mode_e'($urandom_range(0, 2));
        case (sink_mode)
            SINK_OPEN:   m_ready <= 1'b1;
            SINK_CHOPPY: m_ready <= ($urandom_range(0, 3) != 0);
            default:     m_ready <= (sink_count[2:0] == 3'd0);
        endcase
    end

    initial begin : watchdog
        do @(posedge aclk); while (stall_cycles < WATCHDOG_LIMIT);
        $display("strided_conv2d_mac_core regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        layer_cfg = geometry(227, 227, 3, 11, 11, 96, 4);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_reset_geometry();
        test_unit_geometry();
        test_degenerate_geometry();
        test_random_layers();
        wait_drain();
        if (fail_count == 0) begin
            $display("strided_conv2d_mac_core regression: pass");
        end else begin
            $display("strided_conv2d_mac_core regression: fail");
        end
        $finish;
    end

endmodule
